[sv/hmp_pkg.sv]
// hmp_pkg: shared types and constants for the hash message padder.
// Used by hmp_front, hmp_queue, hmp_back and hash_message_padder.
// No dependencies.
`default_nettype none

package hmp_pkg;

  // Input operation codes
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam int WORD_W    = 64;
  localparam int COUNT_W   = 61;
  localparam int PART_W    = 56;
  localparam int ZCNT_W    = 3;
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Queue depth between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // One queued request: either a full data word or an end-of-message job
  typedef struct packed {
    logic              is_end;  // 1: padding job, 0: plain data word
    logic [WORD_W-1:0] word;    // data word, or first padding word with 0x80
    logic [ZCNT_W-1:0] zeros;   // all-zero words between pad word and length
    logic [WORD_W-1:0] len;     // bit length, already in output byte order
  } entry_t;

endpackage

`default_nettype wire

[sv/hmp_front.sv]
// hmp_front: accepts input requests, packs bytes into words, counts the
// message, and turns end-of-message into a padding job. Depends on hmp_pkg.
`default_nettype none

module hmp_front
  import hmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  input  wire logic        len_lsb_first,
  output logic             push,
  output entry_t           push_entry
);

  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [PART_W-1:0]  part_r, part_nxt;
  logic [2:0]         fill;
  logic [2:0]         widx;
  logic [WORD_W-1:0]  bits;
  logic [WORD_W-1:0]  bits_le;
  logic [WORD_W-1:0]  pad_word;
  logic [5:0]         pad_sh;

  assign fill = cnt_r[2:0];
  assign widx = cnt_r[5:3];
  assign bits = {cnt_r, 3'b000};

  // Byte swap for little-endian length
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bits_le[8*i +: 8] = bits[8*(7-i) +: 8];
    end
  end

  // Partial bytes followed by the 0x80 mark, left-aligned in the word
  assign pad_sh   = {3'd7 - fill, 3'b000};
  assign pad_word = {part_r, PAD_MARK} << pad_sh;

  // Request to the back end
  always_comb begin
    push             = 1'b0;
    push_entry.is_end = 1'b0;
    push_entry.word  = {part_r, data_byte};
    push_entry.zeros = 3'd6 - widx;  // wraps to 7 when the mark lands in the last word
    push_entry.len   = len_lsb_first ? bits_le : bits;
    if (accept) begin
      if (operation == OP_END) begin
        push              = 1'b1;
        push_entry.is_end = 1'b1;
        push_entry.word   = pad_word;
      end else if (fill == 3'd7) begin
        push = 1'b1;
      end
    end
  end

  // Byte count and partial word
  always_comb begin
    cnt_nxt  = cnt_r;
    part_nxt = part_r;
    if (accept) begin
      if (operation == OP_END) begin
        cnt_nxt  = '0;
        part_nxt = '0;
      end else begin
        cnt_nxt  = cnt_r + COUNT_W'(1);
        part_nxt = (fill == 3'd7) ? '0 : {part_r[PART_W-9:0], data_byte};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      part_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      part_r <= part_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/hmp_queue.sv]
// hmp_queue: short FIFO of requests between front and back end.
// Depends on hmp_pkg.
`default_nettype none

module hmp_queue
  import hmp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        not_empty,
  output entry_t      head
);

  entry_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[sv/hmp_back.sv]
// hmp_back: expands queued requests into output words through a
// registered output stage. Depends on hmp_pkg.
`default_nettype none

module hmp_back
  import hmp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire entry_t        head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [WORD_W-1:0]  out_word,
  output logic               out_final
);

  localparam logic [1:0] PH_PAD  = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  logic [1:0]         phase_r, phase_nxt;
  logic [ZCNT_W-1:0]  zcnt_r, zcnt_nxt;
  logic               valid_r, valid_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic               final_r, final_nxt;
  logic               load;

  assign load = head_valid && (!valid_r || out_ready);

  // Sequencer over the head request
  always_comb begin
    phase_nxt = phase_r;
    zcnt_nxt  = zcnt_r;
    word_nxt  = word_r;
    final_nxt = final_r;
    valid_nxt = valid_r && !out_ready;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = 1'b1;
      final_nxt = 1'b0;
      if (!head.is_end) begin
        word_nxt = head.word;
        pop      = 1'b1;
      end else begin
        case (phase_r)
          PH_PAD: begin
            word_nxt  = head.word;
            zcnt_nxt  = head.zeros;
            phase_nxt = (head.zeros == '0) ? PH_LEN : PH_ZERO;
          end
          PH_ZERO: begin
            word_nxt = '0;
            zcnt_nxt = zcnt_r - ZCNT_W'(1);
            if (zcnt_r == ZCNT_W'(1)) begin
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            word_nxt  = head.len;
            final_nxt = 1'b1;
            pop       = 1'b1;
            phase_nxt = PH_PAD;
          end
          default: begin
            phase_nxt = PH_PAD;
            valid_nxt = valid_r && !out_ready;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PAD;
      zcnt_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      zcnt_r  <= zcnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    final_r <= final_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_final = final_r;

endmodule

`default_nettype wire

[sv/hash_message_padder.sv]
// hash_message_padder: one input byte request per cycle while the 4-entry
// request queue has room. Accepted words pass the queue and then the output
// register. End of message yields 8 - (count/8 mod 8) words, or 9 when the
// mark falls in the last word of a block, sent back to back by the back-end
// sequencer at one word per cycle while out_ready is high. Synchronous
// active-low reset clears counters, queue and config (big-endian length).
`default_nettype none

module hash_message_padder
  import hmp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_length_little_endian,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_operation,
  input  wire logic [7:0]   in_data_byte,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [63:0]       out_padded_word,
  output logic              out_final_word
);

  logic   le_r;
  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   full;
  logic   not_empty;
  entry_t head;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      le_r <= cfg_length_little_endian;
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  hmp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .operation     (in_operation),
    .data_byte     (in_data_byte),
    .len_lsb_first (le_r),
    .push          (push),
    .push_entry    (push_entry)
  );

  hmp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .not_empty  (not_empty),
    .head       (head)
  );

  hmp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_padded_word),
    .out_final  (out_final_word)
  );

endmodule

`default_nettype wire

[bench/hash_message_padder_tb.sv]
`timescale 1ns / 1ps
// hash_message_padder_tb: self-checking bench for the MD5/SHA message padder.
// Sends byte and end-of-message requests, predicts the padded words, checks them.
// Depends on hmp_pkg and hash_message_padder.

module hash_message_padder_tb;
  import hmp_pkg::*;

  localparam int HOLD_OFF_CYCLES = 200;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_ITEMS    = 165;

  // Receiver stall styles
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } padded_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_length_little_endian = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_operation = OP_DATA;
  logic [7:0]        in_data_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [63:0]       out_padded_word;
  logic              out_final_word;

  // Predictor state: running message length, bytes not yet forming a word
  logic [COUNT_W-1:0] msg_bytes = '0;
  logic [PART_W-1:0]  part_bytes = '0;
  logic               len_le = 1'b0;

  padded_word_t pending_words[$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           burst_left = 0;
  logic         sender_gaps = 1'b1;
  logic         hold_off_req = 1'b0;

  hash_message_padder i_dut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_valid                (cfg_valid),
    .cfg_ready                (cfg_ready),
    .cfg_length_little_endian (cfg_length_little_endian),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_operation             (in_operation),
    .in_data_byte             (in_data_byte),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_padded_word          (out_padded_word),
    .out_final_word           (out_final_word)
  );

  always #6 clk = ~clk;

  // Work out the words one accepted request produces
  task automatic predict_padding(input logic op, input logic [7:0] data);
    logic [7:0]        tail[$];
    logic [WORD_W-1:0] word;
    logic [63:0]       bit_len;
    padded_word_t      res;
    int                fill;
    int                pos;
    int                sh;
    if (op == OP_DATA) begin
      word = {part_bytes, data};
      msg_bytes = msg_bytes + 1'b1;
      if (msg_bytes[2:0] == 3'd0) begin
        res.word = word;
        res.last = 1'b0;
        pending_words.push_back(res);
        part_bytes = '0;
      end else begin
        part_bytes = word[PART_W-1:0];
      end
    end else begin
      fill = msg_bytes[2:0];
      pos = msg_bytes[5:0];
      bit_len = {msg_bytes, 3'b000};
      // leftover bytes, earliest first, then the mark and zero fill
      for (int i = fill - 1; i >= 0; i--) tail.push_back(part_bytes[8*i +: 8]);
      tail.push_back(PAD_MARK);
      pos = (pos + 1) % 64;
      while (pos != 56) begin
        tail.push_back(8'h00);
        pos = (pos + 1) % 64;
      end
      for (int i = 0; i < 8; i++) begin
        sh = len_le ? i : 7 - i;
        tail.push_back(bit_len[8*sh +: 8]);
      end
      for (int k = 0; k < tail.size(); k += 8) begin
        res.word = {tail[k], tail[k+1], tail[k+2], tail[k+3],
                    tail[k+4], tail[k+5], tail[k+6], tail[k+7]};
        res.last = (k + 8 == tail.size());
        pending_words.push_back(res);
      end
      msg_bytes = '0;
      part_bytes = '0;
    end
  endtask

  // Offer one request, with a random gap between bursts
  task automatic send_request(input logic op, input logic [7:0] data);
    int gap;
    gap = 0;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    predict_padding(op, data);
    items_sent++;
  endtask

  // A message of random bytes closed by an end request
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_request(OP_DATA, 8'($urandom_range(0, 255)));
    send_request(OP_END, 8'($urandom_range(0, 255)));
  endtask

  // Let every expected word come out, then allow for the pipeline
  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length_order(input logic little);
    drain_words();
    cfg_valid                <= 1'b1;
    cfg_length_little_endian <= little;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_le = little;
  endtask

  // Empty message pads to one full block; data byte of the end request ignored
  task automatic test_empty_message();
    write_length_order(1'b0);
    send_request(OP_END, 8'hFF);
  endtask

  // Byte extremes, a message of exactly one word, then one with a partial word
  task automatic test_byte_extremes();
    logic [7:0] pattern[8];
    pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};
    foreach (pattern[i]) send_request(OP_DATA, pattern[i]);
    send_request(OP_END, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_END, 8'hA5);
  endtask

  // Length written least significant byte first
  task automatic test_length_lsb_first();
    write_length_order(1'b1);
    send_message(5);
    send_request(OP_END, 8'h3C);
  endtask

  // Receiver holds off while the sender keeps pushing, filling the request queue
  task automatic test_backpressure();
    drain_words();
    sender_gaps = 1'b0;
    hold_off_req = 1'b1;
    send_message(60);
    sender_gaps = 1'b1;
  endtask

  // Random messages, weighted toward the block boundary, random length order
  task automatic test_random_messages();
    int first;
    int pick;
    int len;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) write_length_order(1'($urandom_range(0, 1)));
      sender_gaps = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 15);
      else if (pick < 9) len = $urandom_range(52, 70);
      else len = $urandom_range(100, 135);
      send_message(len);
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver: random stall styles, plus a long hold-off on request
  initial begin : out_side
    int       hold_left;
    int       mode_left;
    int       cyc;
    rx_mode_t mode;
    hold_left = 0;
    mode_left = 0;
    cyc = 0;
    mode = RX_ALWAYS;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= (cyc % 5 != 0) && (cyc % 7 != 3);
        endcase
      end
    end
  end

  // Compare every accepted word with the oldest prediction
  always @(posedge clk) begin : check_words
    padded_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: padded_word %h final_word %b",
               out_padded_word, out_final_word);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (out_padded_word !== want.word) begin
          $error("padded_word: expected %h, actual %h", want.word, out_padded_word);
          mismatches++;
        end
        if (out_final_word !== want.last) begin
          $error("final_word: expected %b, actual %b", want.last, out_final_word);
          mismatches++;
        end
      end
    end
  end

  initial begin : run_tests
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_message();
    test_byte_extremes();
    test_length_lsb_first();
    test_backpressure();
    test_random_messages();
    drain_words();
    if (mismatches == 0) begin
      $display("hash_message_padder verification clean");
    end else begin
      $display("hash_message_padder verification failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin : watchdog
    #3_000_000;
    $display("hash_message_padder verification failed");
    $finish;
  end

endmodule

[sim.f]
sv/hmp_pkg.sv
sv/hmp_front.sv
sv/hmp_queue.sv
sv/hmp_back.sv
sv/hash_message_padder.sv
bench/hash_message_padder_tb.sv
